// ----- rtl/rvds_pkg.sv -----
// Package for the RV32I decode and fetch steering block.
// Holds major opcode constants, operation codes, steering actions and the item types.
// No dependencies.
`default_nettype none

package rvds_pkg;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // funct7 values.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [5:0] {
    OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL  = 6'd2,  OP_JALR = 6'd3,
    OP_LB    = 6'd4,  OP_LH    = 6'd5,  OP_LW   = 6'd6,  OP_LBU  = 6'd7,
    OP_LHU   = 6'd8,  OP_ADDI  = 6'd9,  OP_SLTI = 6'd10, OP_SLTIU = 6'd11,
    OP_XORI  = 6'd12, OP_ORI   = 6'd13, OP_ANDI = 6'd14, OP_SLLI = 6'd15,
    OP_SRLI  = 6'd16, OP_SRAI  = 6'd17, OP_BEQ  = 6'd18, OP_BNE  = 6'd19,
    OP_BLT   = 6'd20, OP_BGE   = 6'd21, OP_BLTU = 6'd22, OP_BGEU = 6'd23,
    OP_SB    = 6'd24, OP_SH    = 6'd25, OP_SW   = 6'd26, OP_ADD  = 6'd27,
    OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT  = 6'd30, OP_SLTU = 6'd31,
    OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA  = 6'd34, OP_OR   = 6'd35,
    OP_AND   = 6'd36
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REDIRECT = 2'd1,
    ACT_STALL    = 2'd2
  } action_t;

  typedef struct packed {
    logic [31:0]        table_target;
    logic               table_hit;
    logic [31:0]        instr_pc;
    logic signed [12:0] imm_value;
    logic [6:0]         funct7;
    logic [2:0]         funct3;
    logic [6:0]         opcode;
  } instr_t;

  typedef struct packed {
    logic        prediction_made;
    logic [31:0] fetch_target;
    action_t     fetch_action;
    logic        illegal;
    op_t         op_code;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/rvds_decode.sv -----
// Combinational classifier: RV32I operation code, illegal flag and fetch steering.
// Depends on rvds_pkg.
`default_nettype none

module rvds_decode
  import rvds_pkg::*;
(
  input  instr_t  instr,
  output result_t res
);

  op_t  op;
  logic bad;
  logic imm_pos;

  always_comb begin
    op  = OP_LUI;
    bad = 1'b0;
    case (instr.opcode)
      OPC_LUI:   op = OP_LUI;
      OPC_AUIPC: op = OP_AUIPC;
      OPC_JAL:   op = OP_JAL;
      OPC_JALR: begin
        op  = OP_JALR;
        bad = (instr.funct3 != 3'd0);
      end
      OPC_LOAD: begin
        case (instr.funct3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          default: bad = 1'b1;
        endcase
      end
      OPC_OPIMM: begin
        // shift-left immediate takes any funct7
        case (instr.funct3)
          3'd0: op = OP_ADDI;
          3'd1: op = OP_SLLI;
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: begin
            if (instr.funct7 == F7_BASE) begin
              op = OP_SRLI;
            end else if (instr.funct7 == F7_ALT) begin
              op = OP_SRAI;
            end else begin
              bad = 1'b1;
            end
          end
          3'd6:    op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      OPC_BRANCH: begin
        case (instr.funct3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: bad = 1'b1;
        endcase
      end
      OPC_STORE: begin
        case (instr.funct3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          default: bad = 1'b1;
        endcase
      end
      OPC_OP: begin
        if (instr.funct7 == F7_BASE) begin
          case (instr.funct3)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_SLL;
            3'd2:    op = OP_SLT;
            3'd3:    op = OP_SLTU;
            3'd4:    op = OP_XOR;
            3'd5:    op = OP_SRL;
            3'd6:    op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (instr.funct7 == F7_ALT && instr.funct3 == 3'd0) begin
          op = OP_SUB;
        end else if (instr.funct7 == F7_ALT && instr.funct3 == 3'd5) begin
          op = OP_SRA;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
  end

  // strictly positive: sign clear and not zero
  assign imm_pos = !instr.imm_value[12] && (instr.imm_value != 13'sd0);

  always_comb begin
    res                 = '0;
    res.op_code         = op;
    res.fetch_action    = ACT_NONE;
    res.fetch_target    = 32'd0;
    res.prediction_made = 1'b0;
    res.illegal         = 1'b0;
    if (bad) begin
      res.op_code = OP_LUI;
      res.illegal = 1'b1;
    end else if (op == OP_JAL) begin
      if (instr.table_hit) begin
        res.fetch_action = ACT_REDIRECT;
        res.fetch_target = instr.table_target;
      end else begin
        res.fetch_action = ACT_STALL;
      end
    end else if (op == OP_JALR) begin
      res.fetch_action = ACT_STALL;
    end else if (instr.opcode == OPC_BRANCH) begin
      if (imm_pos) begin
        res.fetch_action    = ACT_REDIRECT;
        res.fetch_target    = instr.instr_pc + 32'd4;
        res.prediction_made = 1'b1;
      end else if (instr.table_hit) begin
        res.fetch_action    = ACT_REDIRECT;
        res.fetch_target    = instr.table_target;
        res.prediction_made = 1'b1;
      end else begin
        res.fetch_action = ACT_STALL;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rv32i_decode_fetch_steer.sv -----
// RV32I decode with fetch steering. One item in, one result out, registered in an
// input register and then a result register after the decode logic. A new
// item is taken every cycle while the result side keeps up; a stalled result
// holds in the output register while the input register still takes one more item.
// Depends on rvds_pkg and rvds_decode.
`default_nettype none

module rv32i_decode_fetch_steer
  import rvds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  // opcode[6:0], funct3[9:7], funct7[16:10], imm_value[29:17],
  // instr_pc[61:30], table_target[93:62], zero pad[95:94]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // table_hit
  input  wire logic                  s_tuser,
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  // op_code[5:0], fetch_action[7:6], fetch_target[39:8],
  // prediction_made[40], zero pad[47:41]
  output      logic [OUT_DATA_W-1:0] m_tdata,
  // illegal
  output      logic                  m_tuser
);

  logic    in_valid;
  instr_t  in_item;
  logic    out_valid;
  result_t out_item;
  result_t dec;
  logic    out_adv;

  assign out_adv  = !out_valid || m_tready;
  assign s_tready = !in_valid || out_adv;

  rvds_decode u_decode (
    .instr (in_item),
    .res   (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode       <= s_tdata[6:0];
      in_item.funct3       <= s_tdata[9:7];
      in_item.funct7       <= s_tdata[16:10];
      in_item.imm_value    <= s_tdata[29:17];
      in_item.instr_pc     <= s_tdata[61:30];
      in_item.table_target <= s_tdata[93:62];
      in_item.table_hit    <= s_tuser;
    end
    if (out_adv && in_valid) begin
      out_item <= dec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_item.prediction_made, out_item.fetch_target,
                     out_item.fetch_action, out_item.op_code};
  assign m_tuser  = out_item.illegal;

endmodule

`default_nettype wire

// ----- rtl/rvds_checker.sv -----
// Port-level checks on the decode and fetch steering block, bound to its top level.
// Depends on rvds_pkg and rv32i_decode_fetch_steer.
`default_nettype none

module rvds_checker
  import rvds_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  // hold a stalled result
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an illegal item carries no operation and no steering
  a_illegal_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("illegal item with nonzero fields");

  // target only on a redirect
  a_target_redirect : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:6] != ACT_REDIRECT |-> m_tdata[39:8] == 32'd0)
    else $error("fetch target without redirect");

  // a counted prediction is always a redirecting branch
  a_pred_branch : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |->
      m_tdata[7:6] == ACT_REDIRECT && m_tdata[5:0] >= OP_BEQ && m_tdata[5:0] <= OP_BGEU)
    else $error("prediction on a non-branch");

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rv32i_decode_fetch_steer rvds_checker u_rvds_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for rv32i_decode_fetch_steer: a queue-fed stream driver, a
// result monitor and a decode/steering predictor built on the rvds_pkg types.
// Depends on rvds_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import rvds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Opcodes the block rejects outright.
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct3 values, most named after the register ALU op that uses each.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_GAP  = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Operation per funct3, slot 0 in the low bits; the mask marks legal slots.
  localparam logic [47:0] LOAD_MAP =
    {OP_LUI, OP_LUI, OP_LHU, OP_LBU, OP_LUI, OP_LW, OP_LH, OP_LB};
  localparam logic [7:0] LOAD_OK = 8'b0011_0111;
  localparam logic [47:0] OPIMM_MAP =
    {OP_ANDI, OP_ORI, OP_SRLI, OP_XORI, OP_SLTIU, OP_SLTI, OP_SLLI, OP_ADDI};
  localparam logic [47:0] BRANCH_MAP =
    {OP_BGEU, OP_BLTU, OP_BGE, OP_BLT, OP_LUI, OP_LUI, OP_BNE, OP_BEQ};
  localparam logic [7:0] BRANCH_OK = 8'b1111_0011;
  localparam logic [47:0] STORE_MAP =
    {OP_LUI, OP_LUI, OP_LUI, OP_LUI, OP_LUI, OP_SW, OP_SH, OP_SB};
  localparam logic [7:0] STORE_OK = 8'b0000_0111;
  localparam logic [47:0] OPREG_MAP =
    {OP_AND, OP_OR, OP_SRL, OP_XOR, OP_SLTU, OP_SLT, OP_SLL, OP_ADD};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  instr_t      instr_queue[$];
  result_t     decode_expected[$];
  instr_t      held_instr;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;
  bit          failed = 1'b0;

  rv32i_decode_fetch_steer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic op_t map_slot(logic [47:0] map, logic [2:0] f3);
    return op_t'(map[int'(f3) * 6 +: 6]);
  endfunction

  function automatic result_t steer_decode(instr_t ins);
    result_t r;
    op_t     op;
    logic    bad;
    bad = 1'b0;
    op = OP_LUI;
    case (ins.opcode)
      OPC_LUI:   op = OP_LUI;
      OPC_AUIPC: op = OP_AUIPC;
      OPC_JAL:   op = OP_JAL;
      OPC_JALR: begin
        op = OP_JALR;
        bad = ins.funct3 != F3_ADD;
      end
      OPC_LOAD: begin
        op = map_slot(LOAD_MAP, ins.funct3);
        bad = !LOAD_OK[ins.funct3];
      end
      OPC_OPIMM: begin
        if (ins.funct3 == F3_SR) begin
          op = (ins.funct7 == F7_ALT) ? OP_SRAI : OP_SRLI;
          bad = ins.funct7 != F7_BASE && ins.funct7 != F7_ALT;
        end else begin
          op = map_slot(OPIMM_MAP, ins.funct3);
        end
      end
      OPC_BRANCH: begin
        op = map_slot(BRANCH_MAP, ins.funct3);
        bad = !BRANCH_OK[ins.funct3];
      end
      OPC_STORE: begin
        op = map_slot(STORE_MAP, ins.funct3);
        bad = !STORE_OK[ins.funct3];
      end
      OPC_OP: begin
        if (ins.funct7 == F7_BASE) begin
          op = map_slot(OPREG_MAP, ins.funct3);
        end else if (ins.funct7 == F7_ALT && ins.funct3 == F3_ADD) begin
          op = OP_SUB;
        end else if (ins.funct7 == F7_ALT && ins.funct3 == F3_SR) begin
          op = OP_SRA;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    r = '0;
    r.fetch_action = ACT_NONE;
    r.op_code = OP_LUI;
    if (bad) begin
      r.illegal = 1'b1;
    end else begin
      r.op_code = op;
      if (op == OP_JAL) begin
        if (ins.table_hit) begin
          r.fetch_action = ACT_REDIRECT;
          r.fetch_target = ins.table_target;
        end else begin
          r.fetch_action = ACT_STALL;
        end
      end else if (op == OP_JALR) begin
        r.fetch_action = ACT_STALL;
      end else if (op >= OP_BEQ && op <= OP_BGEU) begin
        // forward branches fall through to the next word, others trust the table on a hit and stall otherwise
        if ($signed(ins.imm_value) > 0) begin
          r.fetch_action = ACT_REDIRECT;
          r.fetch_target = ins.instr_pc + 32'd4;
          r.prediction_made = 1'b1;
        end else if (ins.table_hit) begin
          r.fetch_action = ACT_REDIRECT;
          r.fetch_target = ins.table_target;
          r.prediction_made = 1'b1;
        end else begin
          r.fetch_action = ACT_STALL;
        end
      end
    end
    return r;
  endfunction

  function automatic instr_t instr(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                   logic signed [12:0] imm, logic [31:0] pc,
                                   logic hit, logic [31:0] tgt);
    instr_t it;
    it.opcode = opc;
    it.funct3 = f3;
    it.funct7 = f7;
    it.imm_value = imm;
    it.instr_pc = pc;
    it.table_hit = hit;
    it.table_target = tgt;
    return it;
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    it = instr(7'($urandom), 3'($urandom), 7'($urandom), 13'($urandom),
               $urandom, 1'($urandom), $urandom);
    if ($urandom_range(7) == 0) it.imm_value = '0;
    // mostly real opcodes, the rest anything at all
    if ($urandom_range(9) >= 2) begin
      case ($urandom_range(8))
        0: it.opcode = OPC_LUI;
        1: it.opcode = OPC_AUIPC;
        2: it.opcode = OPC_JAL;
        3: it.opcode = OPC_JALR;
        4: it.opcode = OPC_LOAD;
        5: it.opcode = OPC_OPIMM;
        6: it.opcode = OPC_BRANCH;
        7: it.opcode = OPC_STORE;
        default: it.opcode = OPC_OP;
      endcase
      if ((it.opcode == OPC_OPIMM || it.opcode == OPC_OP) && $urandom_range(4) != 0)
        it.funct7 = $urandom_range(1) ? F7_ALT : F7_BASE;
      if (it.opcode == OPC_JALR && $urandom_range(3) != 0) it.funct3 = F3_ADD;
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Set the idle mix, queue random instructions and wait for every result.
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) instr_queue.push_back(random_instr());
    while (instr_queue.size() != 0 || s_tvalid || decode_expected.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    instr_t nxt;
    logic   go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_expected.push_back(steer_decode(held_instr));
      if (!s_tvalid || s_tready) begin
        go = instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (go) begin
          nxt = instr_queue.pop_front();
          held_instr <= nxt;
          s_tdata <= {2'b00, nxt.table_target, nxt.instr_pc, nxt.imm_value,
                      nxt.funct7, nxt.funct3, nxt.opcode};
          s_tuser <= nxt.table_hit;
        end
        s_tvalid <= go;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decode_expected.size() == 0) begin
          $error("result item with no instruction outstanding");
          failed = 1'b1;
        end else begin
          want = decode_expected.pop_front();
          check_field("op_code", 32'(want.op_code), 32'(m_tdata[5:0]));
          check_field("illegal", 32'(want.illegal), 32'(m_tuser));
          check_field("fetch_action", 32'(want.fetch_action), 32'(m_tdata[7:6]));
          check_field("fetch_target", want.fetch_target, m_tdata[39:8]);
          check_field("prediction_made", 32'(want.prediction_made), 32'(m_tdata[40]));
        end
      end
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rv32i_decode_fetch_steer regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    instr_queue.push_back(instr(OPC_LUI, F3_AND, 7'h7f, -13'sd4096, 32'hffff_ffff,
                                1'b1, 32'hffff_ffff));
    instr_queue.push_back(instr(OPC_AUIPC, F3_ADD, 7'h00, 13'sd0, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_JAL, F3_SR, 7'h55, 13'sd12, 32'h100, 1'b1,
                                32'h8000_0000));
    instr_queue.push_back(instr(OPC_JAL, F3_ADD, 7'h00, 13'sd12, 32'h100, 1'b0,
                                32'h8000_0000));
    instr_queue.push_back(instr(OPC_JALR, F3_ADD, 7'h7f, 13'sd4, 32'h200, 1'b1, 32'h40));
    // JALR with a nonzero funct3 is rejected
    instr_queue.push_back(instr(OPC_JALR, F3_SLL, 7'h00, 13'sd4, 32'h200, 1'b1, 32'h40));
    // forward branch at the top of memory wraps its fall-through to zero
    instr_queue.push_back(instr(OPC_BRANCH, F3_ADD, 7'h00, 13'sd1, 32'hffff_fffc,
                                1'b1, 32'h1234));
    instr_queue.push_back(instr(OPC_BRANCH, F3_SLL, 7'h3c, 13'sd4095, 32'h1000,
                                1'b1, 32'h2000));
    instr_queue.push_back(instr(OPC_BRANCH, F3_XOR, 7'h00, 13'sd0, 32'h1000,
                                1'b1, 32'hdead_beef));
    instr_queue.push_back(instr(OPC_BRANCH, F3_SR, 7'h00, -13'sd4096, 32'h1000,
                                1'b0, 32'hdead_beef));
    instr_queue.push_back(instr(OPC_BRANCH, F3_OR, 7'h00, -13'sd1, 32'h1000,
                                1'b1, 32'h0000_0800));
    instr_queue.push_back(instr(OPC_BRANCH, F3_AND, 7'h00, -13'sd2, 32'h1000,
                                1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_BRANCH, F3_WORD, 7'h00, 13'sd8, 32'h1000,
                                1'b1, 32'h40));
    instr_queue.push_back(instr(OPC_LOAD, F3_WORD, 7'h7f, 13'sd0, 32'h0, 1'b1, 32'h44));
    instr_queue.push_back(instr(OPC_LOAD, F3_GAP, 7'h00, 13'sd0, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_LOAD, F3_AND, 7'h00, 13'sd0, 32'h0, 1'b0, 32'h0));
    // SLLI does not look at funct7
    instr_queue.push_back(instr(OPC_OPIMM, F3_SLL, 7'h7f, 13'sd5, 32'h0, 1'b1, 32'h0));
    instr_queue.push_back(instr(OPC_OPIMM, F3_SR, F7_BASE, 13'sd5, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_OPIMM, F3_SR, F7_ALT, 13'sd5, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_OPIMM, F3_SR, 7'h21, 13'sd5, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_OP, F3_ADD, F7_BASE, 13'sd3, 32'h0, 1'b1, 32'h8));
    instr_queue.push_back(instr(OPC_OP, F3_ADD, F7_ALT, 13'sd3, 32'h0, 1'b1, 32'h8));
    instr_queue.push_back(instr(OPC_OP, F3_SR, F7_ALT, 13'sd3, 32'h0, 1'b1, 32'h8));
    instr_queue.push_back(instr(OPC_OP, F3_SLL, F7_ALT, 13'sd3, 32'h0, 1'b1, 32'h8));
    instr_queue.push_back(instr(OPC_STORE, F3_WORD, 7'h00, 13'sd0, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_STORE, F3_AND, 7'h00, 13'sd0, 32'h0, 1'b0, 32'h0));
    instr_queue.push_back(instr(OPC_FENCE, F3_ADD, 7'h00, 13'sd0, 32'h0, 1'b1, 32'h4));
    instr_queue.push_back(instr(OPC_SYSTEM, F3_ADD, 7'h00, 13'sd0, 32'h0, 1'b1, 32'h4));
    instr_queue.push_back(instr(7'h7f, F3_AND, 7'h7f, -13'sd1, 32'hffff_ffff, 1'b1,
                                32'hffff_ffff));

    run_phase(0, 0, 180);
    run_phase(58, 0, 180);
    run_phase(0, 58, 180);
    run_phase(37, 37, 180);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decode_expected.size() != 0) begin
      $error("%0d result items never arrived", decode_expected.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("rv32i_decode_fetch_steer regression: pass");
    end else begin
      $display("rv32i_decode_fetch_steer regression: fail");
    end
    $finish;
  end

endmodule
